// ----- src/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the fixed-point sphere tracer.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Item codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RAY    = 1'b1;
  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_CUBE   = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_ACTIVE    = 2'd0;
  localparam logic [1:0] REG_STEPS     = 2'd1;
  localparam logic [1:0] REG_DIST      = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  localparam logic signed [51:0] S32_MAX_W = 52'sh0_0000_7FFF_FFFF;
  localparam logic signed [51:0] S32_MIN_W = -52'sh0_0000_8000_0000;
  localparam logic [30:0]        U31_MAX   = 31'h7FFF_FFFF;

  typedef struct packed {
    logic               func;
    logic [3:0]         slot;
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        size;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_z;
  } item_t;

  typedef struct packed {
    logic [4:0]  active_bodies;
    logic [7:0]  step_limit;
    logic [30:0] distance_limit;
    logic [15:0] hit_threshold;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic [3:0]         body_hit;
    logic [7:0]         steps_taken;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic [30:0]        travelled;
  } result_t;

  // Handshake between front queue and march engine
  typedef struct packed {
    logic valid;
    logic pop;
  } qctl_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat_s32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX_W) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN_W) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- src/sst_front.sv -----
// ----------------------------------------------------------------------------
// sst_front
// Input side: accepts beats, drops loads to absent table slots and queues
// the rest in a two-entry buffer for the march engine.
// ----------------------------------------------------------------------------
module sst_front import sst_pkg::*; #(
  parameter int MAX_BODIES = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_pop,
  output item_t q_item
);

  item_t      qmem [2];
  logic [1:0] fill;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       keep;
  logic       push;
  logic       pop;

  // Classify: a load beyond the table is taken and dropped
  assign keep     = (in_item.func == FUNC_RAY) || (int'(in_item.slot) < MAX_BODIES);
  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = qmem[rd_ptr];

  // Store queued items
  always_ff @(posedge clk) begin
    if (push) qmem[wr_ptr] <= in_item;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

// ----- src/sst_isqrt.sv -----
// ----------------------------------------------------------------------------
// sst_isqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sst_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  // Iterate two bits of the radicand per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= n;
        res  <= 64'd0;
        bitv <= 64'h4000_0000_0000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/sst_march.sv -----
// ----------------------------------------------------------------------------
// sst_march
// Back end: body table, per-body distance evaluation and ray advance, with
// a result register towards the output channel.
// ----------------------------------------------------------------------------
module sst_march import sst_pkg::*; #(
  parameter int MAX_BODIES = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  output logic    q_pop,
  input  item_t   q_item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        ext;
  } body_t;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_CHECK  = 12'b0000_0000_0010,
    S_READ   = 12'b0000_0000_0100,
    S_EVAL   = 12'b0000_0000_1000,
    S_SQ     = 12'b0000_0001_0000,
    S_SUM    = 12'b0000_0010_0000,
    S_ROOT   = 12'b0000_0100_0000,
    S_DIST   = 12'b0000_1000_0000,
    S_DECIDE = 12'b0001_0000_0000,
    S_MUL    = 12'b0010_0000_0000,
    S_ADV    = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t             state;
  body_t              mem [MAX_BODIES];
  body_t              rd_body;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   best_idx;
  logic [IDX_W+3:0]   slot_ext;
  logic [IDX_W+3:0]   best_ext;
  logic signed [31:0] px, py, pz;
  logic signed [17:0] dx, dy, dz;
  logic [7:0]         steps;
  logic [30:0]        trav;
  logic               hit;
  logic signed [31:0] best;
  logic [30:0]        m0, m1, m2;
  logic [61:0]        sq0, sq1, sq2;
  logic signed [49:0] pr0, pr1, pr2;
  logic               mem_we;
  logic               sq_start;
  logic               sq_done;
  logic [31:0]        sq_root;
  logic [63:0]        sq_sum;
  logic signed [31:0] body_gap;
  logic [31:0]        trav_sum;

  // Magnitude of one axis difference, saturated, less the half-size for cubes
  function automatic logic [30:0] axis_mag(input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic cube,
                                           input logic [30:0] ext);
    logic signed [32:0] d;
    logic [32:0]        m;
    logic [30:0]        s;
    d = 33'(a) - 33'(b);
    m = d[32] ? 33'(-d) : 33'(d);
    s = (m > 33'(U31_MAX)) ? U31_MAX : m[30:0];
    if (cube) s = (s > ext) ? s - ext : 31'd0;
    return s;
  endfunction

  // Move one coordinate by floor(dist * dir / 2^FRAC_BITS), saturating
  function automatic logic signed [31:0] advance(input logic signed [31:0] p,
                                                 input logic signed [49:0] pr);
    logic signed [49:0] sh;
    sh = pr >>> FRAC_BITS;
    return sat_s32(52'(p) + 52'(sh));
  endfunction

  // Clamp the active count to the table
  always_comb begin
    if (cfg.active_bodies == 5'd0) last_idx = '0;
    else if (int'(cfg.active_bodies) > MAX_BODIES) last_idx = IDX_W'(MAX_BODIES - 1);
    else last_idx = IDX_W'(cfg.active_bodies - 5'd1);
  end

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign mem_we   = q_pop && (q_item.func == FUNC_LOAD);
  assign slot_ext = {{IDX_W{1'b0}}, q_item.slot};
  assign best_ext = {4'd0, best_idx};
  assign sq_start = (state == S_SUM);
  assign sq_sum   = 64'(sq0) + 64'(sq1) + 64'(sq2);
  assign trav_sum = 32'(trav) + 32'(best[30:0]);

  always_comb begin
    if (rd_body.kind == KIND_CUBE) body_gap = sat_s32(52'(sq_root));
    else body_gap = sat_s32(52'(sq_root) - 52'(rd_body.ext));
  end

  // Body table: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_ext[IDX_W-1:0]] <= '{kind: q_item.kind, cx: q_item.pos_x,
                                    cy: q_item.pos_y, cz: q_item.pos_z,
                                    ext: q_item.size};
    end
    rd_body <= mem[idx];
  end

  sst_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .n     (sq_sum),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Sequence the march
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_OUT) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_item.func == FUNC_RAY) begin
            px    <= q_item.pos_x;
            py    <= q_item.pos_y;
            pz    <= q_item.pos_z;
            dx    <= q_item.dir_x;
            dy    <= q_item.dir_y;
            dz    <= q_item.dir_z;
            steps <= 8'd0;
            trav  <= 31'd0;
            hit   <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          idx <= '0;
          if (steps < cfg.step_limit && trav < cfg.distance_limit) state <= S_READ;
          else state <= S_OUT;
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          m0    <= axis_mag(px, rd_body.cx, rd_body.kind, rd_body.ext);
          m1    <= axis_mag(py, rd_body.cy, rd_body.kind, rd_body.ext);
          m2    <= axis_mag(pz, rd_body.cz, rd_body.kind, rd_body.ext);
          state <= S_SQ;
        end
        S_SQ: begin
          sq0   <= m0 * m0;
          sq1   <= m1 * m1;
          sq2   <= m2 * m2;
          state <= S_SUM;
        end
        S_SUM: state <= S_ROOT;
        S_ROOT: begin
          if (sq_done) state <= S_DIST;
        end
        S_DIST: begin
          // Keep the nearest body, lowest index on a tie
          if (idx == '0 || best > body_gap) begin
            best     <= body_gap;
            best_idx <= idx;
          end
          if (idx == last_idx) begin
            state <= S_DECIDE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_DECIDE: begin
          if (best < $signed({16'd0, cfg.hit_threshold})) begin
            hit   <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          pr0   <= best * dx;
          pr1   <= best * dy;
          pr2   <= best * dz;
          state <= S_ADV;
        end
        S_ADV: begin
          px    <= advance(px, pr0);
          py    <= advance(py, pr1);
          pz    <= advance(pz, pr2);
          trav  <= (trav_sum > 32'(U31_MAX)) ? U31_MAX : trav_sum[30:0];
          steps <= steps + 8'd1;
          state <= S_CHECK;
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res.hit         <= hit;
            res.body_hit    <= hit ? best_ext[3:0] : 4'd0;
            res.steps_taken <= steps;
            res.end_x       <= px;
            res.end_y       <= py;
            res.end_z       <= pz;
            res.travelled   <= trav;
            res_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/sdf_sphere_tracer.sv -----
// ----------------------------------------------------------------------------
// sdf_sphere_tracer
// Fixed-point sphere tracer over a table of spheres and cubes.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser[0] selects load (0) or ray (1). A load beat
// writes one body table entry and gives no result; a ray beat gives one
// result beat on m_axis. Configuration sits on the APB port; the user must
// write it only while the block is idle, as the block does not enforce this.
// A ray runs the per-body loop once for each step, and a ray that ends on a
// hit runs it once more without an advance; each body in the loop waits on
// the square root unit.
// Items are worked one at a time; a two-entry queue at the input and the
// result register let both sides stall on their own.
// Reset clears the queue, engine and result valid and restores the default
// registers; the body table holds no value until loaded.
// A stalled receiver holds the result; the engine still finishes the
// next ray and waits for the result register to free.
// ----------------------------------------------------------------------------
module sdf_sphere_tracer import sst_pkg::*; #(
  parameter int MAX_BODIES = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot, pos_x, pos_y, pos_z, size, dir_x, dir_y, dir_z
  input  logic [191:0] s_axis_tdata,
  // func, kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // body_hit, steps_taken, end_x, end_y, end_z, travelled
  output logic [143:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   q_item;
  qctl_t   qctl;
  result_t res;

  // Unpack input beat
  assign in_item.func  = s_axis_tuser[0];
  assign in_item.kind  = s_axis_tuser[1];
  assign in_item.slot  = s_axis_tdata[3:0];
  assign in_item.pos_x = s_axis_tdata[35:4];
  assign in_item.pos_y = s_axis_tdata[67:36];
  assign in_item.pos_z = s_axis_tdata[99:68];
  assign in_item.size  = s_axis_tdata[130:100];
  assign in_item.dir_x = s_axis_tdata[148:131];
  assign in_item.dir_y = s_axis_tdata[166:149];
  assign in_item.dir_z = s_axis_tdata[184:167];

  // Pack result beat
  assign m_axis_tuser = res.hit;
  assign m_axis_tdata = {5'd0, res.travelled, res.end_z, res.end_y, res.end_x,
                         res.steps_taken, res.body_hit};

  // Register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_bodies  <= 5'd6;
      cfg.step_limit     <= 8'd100;
      cfg.distance_limit <= 31'd9830400;
      cfg.hit_threshold  <= 16'd655;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_ACTIVE:    cfg.active_bodies  <= pwdata[4:0];
        REG_STEPS:     cfg.step_limit     <= pwdata[7:0];
        REG_DIST:      cfg.distance_limit <= pwdata[30:0];
        REG_THRESHOLD: cfg.hit_threshold  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ACTIVE:    prdata = {27'd0, cfg.active_bodies};
      REG_STEPS:     prdata = {24'd0, cfg.step_limit};
      REG_DIST:      prdata = {1'b0, cfg.distance_limit};
      REG_THRESHOLD: prdata = {16'd0, cfg.hit_threshold};
      default:       prdata = 32'd0;
    endcase
  end

  sst_front #(
    .MAX_BODIES (MAX_BODIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (qctl.valid),
    .q_pop    (qctl.pop),
    .q_item   (q_item)
  );

  sst_march #(
    .MAX_BODIES (MAX_BODIES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_march (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (qctl.valid),
    .q_pop     (qctl.pop),
    .q_item    (q_item),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

endmodule

// ----- src/sst_checker.sv -----
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks on the result channel and configuration port.
// ----------------------------------------------------------------------------
module sst_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         pready
);

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // A miss reports body zero
  a_miss_body: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[3:0] == 4'd0)
    else $error("miss with nonzero body index");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Register port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind sdf_sphere_tracer sst_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed-point sphere tracer: loads the body
// table, marches directed and random rays under several register settings,
// predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import sst_pkg::*;

  localparam int  BODIES     = 16;
  localparam int  FRAC       = 16;
  localparam int  CYCLE_CAP  = 8000000;
  localparam int  SETTLE     = 60;
  localparam longint SMAX    = 64'sd2147483647;
  localparam longint SMIN    = -64'sd2147483648;
  localparam int  ONE        = 65536;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  sdf_sphere_tracer dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Shadow body table and registers
  logic              tbl_kind [BODIES];
  logic signed [31:0] tbl_cx  [BODIES];
  logic signed [31:0] tbl_cy  [BODIES];
  logic signed [31:0] tbl_cz  [BODIES];
  logic [30:0]       tbl_ext  [BODIES];
  cfg_t              regs;

  result_t   pending_hits[$];
  int        cycles = 0;
  int        errors = 0;
  bit        gaps_on = 1'b1;
  bit        ready_free = 1'b0;
  int        hold_off = 0;

  // Clock and cycle watchdog
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint unsigned gap_mag(input longint a, input longint b);
    longint d;
    longint unsigned m;
    d = a - b;
    m = (d < 0) ? longint'(-d) : longint'(d);
    return (m > SMAX) ? SMAX : m;
  endfunction

  function automatic longint surface_gap(input int i, input longint px, input longint py,
                                         input longint pz);
    longint unsigned m [3];
    longint unsigned sum;
    longint unsigned ext;
    m[0] = gap_mag(px, tbl_cx[i]);
    m[1] = gap_mag(py, tbl_cy[i]);
    m[2] = gap_mag(pz, tbl_cz[i]);
    ext = tbl_ext[i];
    sum = 0;
    if (tbl_kind[i] == KIND_CUBE) begin
      for (int k = 0; k < 3; k++) m[k] = (m[k] > ext) ? m[k] - ext : 0;
      for (int k = 0; k < 3; k++) sum += m[k] * m[k];
      return clamp32(longint'(root_floor(sum)));
    end
    for (int k = 0; k < 3; k++) sum += m[k] * m[k];
    return clamp32(longint'(root_floor(sum)) - longint'(ext));
  endfunction

  function automatic longint dir_move(input longint span, input longint dir);
    longint prod;
    prod = span * dir;
    if (prod >= 0) return prod >>> FRAC;
    return -(((-prod) + ((64'd1 << FRAC) - 1)) >>> FRAC);
  endfunction

  function automatic result_t march_ray(input item_t it);
    result_t r;
    longint p [3];
    longint d [3];
    longint best, t;
    longint unsigned trav;
    int count, bi, best_idx, steps;
    bit hit;
    p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
    d[0] = it.dir_x; d[1] = it.dir_y; d[2] = it.dir_z;
    count = regs.active_bodies;
    if (count == 0) count = 1;
    if (count > BODIES) count = BODIES;
    trav = 0; steps = 0; hit = 0; best_idx = 0;
    while (steps < regs.step_limit && !hit && trav < regs.distance_limit) begin
      best = surface_gap(0, p[0], p[1], p[2]);
      bi = 0;
      for (int i = 1; i < count; i++) begin
        t = surface_gap(i, p[0], p[1], p[2]);
        if (best > t) begin
          best = t;
          bi = i;
        end
      end
      if (best < longint'(regs.hit_threshold)) begin
        hit = 1;
        best_idx = bi;
      end else begin
        for (int k = 0; k < 3; k++) p[k] = clamp32(p[k] + dir_move(best, d[k]));
        trav += best;
        if (trav > SMAX) trav = SMAX;
        steps++;
      end
    end
    r.hit         = hit;
    r.body_hit    = hit ? best_idx[3:0] : 4'd0;
    r.steps_taken = steps[7:0];
    r.end_x       = p[0][31:0];
    r.end_y       = p[1][31:0];
    r.end_z       = p[2][31:0];
    r.travelled   = trav[30:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one beat, hold until accepted, then record what it should cause
  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tdata <= {7'd0, it.dir_z, it.dir_y, it.dir_x, it.size,
                     it.pos_z, it.pos_y, it.pos_x, it.slot};
    s_axis_tuser <= {it.kind, it.func};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    if (it.func == FUNC_RAY) begin
      pending_hits.push_back(march_ray(it));
    end else begin
      tbl_kind[it.slot] = it.kind;
      tbl_cx[it.slot]   = it.pos_x;
      tbl_cy[it.slot]   = it.pos_y;
      tbl_cz[it.slot]   = it.pos_z;
      tbl_ext[it.slot]  = it.size;
    end
  endtask

  // Drop valid and wait for the block to drain
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ACTIVE:    regs.active_bodies  = val[4:0];
      REG_STEPS:     regs.step_limit     = val[7:0];
      REG_DIST:      regs.distance_limit = val[30:0];
      REG_THRESHOLD: regs.hit_threshold  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int act, input int lim, input int dlim, input int thr);
    wait_idle();
    write_reg(REG_ACTIVE, act);
    write_reg(REG_STEPS, lim);
    write_reg(REG_DIST, dlim);
    write_reg(REG_THRESHOLD, thr);
  endtask

  function automatic item_t load_of(input int slot, input logic kind, input int x,
                                    input int y, input int z, input int sz);
    item_t it;
    it = '0;
    it.func = FUNC_LOAD; it.slot = slot[3:0]; it.kind = kind;
    it.pos_x = x; it.pos_y = y; it.pos_z = z; it.size = sz[30:0];
    return it;
  endfunction

  function automatic item_t ray_of(input int x, input int y, input int z,
                                   input int dx, input int dy, input int dz);
    item_t it;
    it = '0;
    it.func = FUNC_RAY;
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.dir_x = dx[17:0]; it.dir_y = dy[17:0]; it.dir_z = dz[17:0];
    return it;
  endfunction

  // Ray aimed from a random offset towards one of the searched bodies
  function automatic item_t aimed_ray();
    int cnt, tgt;
    real ox, oy, oz, len;
    longint sx, sy, sz;
    item_t it;
    cnt = (regs.active_bodies == 0) ? 1 : (regs.active_bodies > BODIES) ? BODIES
          : regs.active_bodies;
    tgt = $urandom_range(0, cnt - 1);
    ox = real'($urandom_range(0, 80)) - 40.0 + 0.5;
    oy = real'($urandom_range(0, 80)) - 40.0;
    oz = real'($urandom_range(0, 80)) - 40.0;
    len = $sqrt(ox * ox + oy * oy + oz * oz);
    sx = clamp32(longint'(tbl_cx[tgt]) + longint'(ox * ONE));
    sy = clamp32(longint'(tbl_cy[tgt]) + longint'(oy * ONE));
    sz = clamp32(longint'(tbl_cz[tgt]) + longint'(oz * ONE));
    it = ray_of(sx, sy, sz, $rtoi(-ox / len * ONE), $rtoi(-oy / len * ONE),
                $rtoi(-oz / len * ONE));
    it.slot = $urandom; it.kind = $urandom; it.size = $urandom;
    return it;
  endfunction

  function automatic int rand_dir();
    return int'($urandom_range(0, 2 * ONE)) - ONE;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_hits.size() == 0) begin
        $error("result beat with no ray outstanding");
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (m_axis_tuser !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_axis_tuser); errors++;
        end
        if (m_axis_tdata[3:0] !== want.body_hit) begin
          $error("body_hit: expected %0d, got %0d", want.body_hit, m_axis_tdata[3:0]);
          errors++;
        end
        if (m_axis_tdata[11:4] !== want.steps_taken) begin
          $error("steps_taken: expected %0d, got %0d", want.steps_taken,
                 m_axis_tdata[11:4]);
          errors++;
        end
        if (m_axis_tdata[43:12] !== want.end_x) begin
          $error("end_x: expected %0h, got %0h", want.end_x, m_axis_tdata[43:12]);
          errors++;
        end
        if (m_axis_tdata[75:44] !== want.end_y) begin
          $error("end_y: expected %0h, got %0h", want.end_y, m_axis_tdata[75:44]);
          errors++;
        end
        if (m_axis_tdata[107:76] !== want.end_z) begin
          $error("end_z: expected %0h, got %0h", want.end_z, m_axis_tdata[107:76]);
          errors++;
        end
        if (m_axis_tdata[138:108] !== want.travelled) begin
          $error("travelled: expected %0h, got %0h", want.travelled,
                 m_axis_tdata[138:108]);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, free-running stretches, and long hold-offs
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (ready_free) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                       ($urandom_range(0, 99) < 3 ? 1'b0 : 1'b0);
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) ready_free <= ~ready_free;
  end

  // ---------------------------------------------------------------- tests
  // Two equal spheres at the head for the tie rule, then a line of bodies
  task automatic test_scene_and_defaults();
    send_item(load_of(0, KIND_SPHERE, 0, 0, 20 * ONE, ONE));
    send_item(load_of(1, KIND_SPHERE, 0, 0, 20 * ONE, ONE));
    for (int i = 2; i < BODIES; i++)
      send_item(load_of(i, i[0] ? KIND_CUBE : KIND_SPHERE, i * 6 * ONE, 0, 20 * ONE,
                        ONE));
    send_item(ray_of(0, 0, 0, 0, 0, ONE));
    send_item(ray_of(4 * 6 * ONE, 0, 0, 0, 0, ONE));
    send_item(ray_of(5 * 6 * ONE, 0, 0, 0, 0, ONE));
  endtask

  task automatic test_directed();
    set_regs(16, 40, 32'h7FFF_FFFF, 655);
    // Inside a cube, sphere centres, far corners, extreme directions
    send_item(ray_of(3 * 6 * ONE, 0, 20 * ONE, 0, ONE, 0));
    send_item(ray_of(0, 0, 20 * ONE, -ONE, -ONE, -ONE));
    send_item(ray_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE, ONE, ONE));
    send_item(ray_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -ONE, -ONE, -ONE));
    send_item(ray_of(32'h8000_0000, 0, 32'h7FFF_FFFF, ONE, -ONE, 0));
    send_item(ray_of(10 * ONE, 3 * ONE, 0, -ONE, 0, ONE));
    // Zero step limit, zero distance limit, zero threshold stalling in a cube
    set_regs(0, 0, 100, 1);
    send_item(ray_of(0, 0, 0, 0, 0, ONE));
    set_regs(31, 255, 0, 65535);
    send_item(ray_of(0, 0, 0, 0, 0, ONE));
    set_regs(16, 6, 9830400, 0);
    send_item(ray_of(3 * 6 * ONE, 0, 20 * ONE, 0, 0, ONE));
    send_item(ray_of(0, 0, 0, ONE, 0, 0));
    // Largest step limit, distance limit and threshold once
    set_regs(16, 255, 32'h7FFF_FFFF, 65535);
    send_item(ray_of(9 * 6 * ONE, 0, 20 * ONE, 0, 0, -ONE));
    send_item(ray_of(0, 0, 0, 0, 0, ONE));
  endtask

  // Receiver held off while quick rays pile up at the input
  task automatic test_backpressure();
    set_regs(6, 100, 9830400, 655);
    gaps_on = 1'b0;
    @(negedge clk);
    hold_off = 3000;
    for (int i = 0; i < 8; i++) send_item(ray_of(0, 0, 20 * ONE, 0, 0, ONE));
    gaps_on = 1'b1;
  endtask

  task automatic test_random(input int n);
    int r;
    item_t it;
    for (int ph = 0; ph < 5; ph++) begin
      set_regs(ph == 0 ? 0 : ph == 4 ? 16 : $urandom_range(1, 8), $urandom_range(1, 12),
               ph == 2 ? 32'h7FFF_FFFF : $urandom_range(ONE, 200 * ONE),
               ph == 3 ? 65535 : $urandom_range(1, 4000));
      for (int i = 0; i < n / 5; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          // Well-formed body near the scene
          send_item(load_of($urandom_range(0, 15), $urandom,
                            int'($urandom_range(0, 128 * ONE)) - 64 * ONE,
                            int'($urandom_range(0, 128 * ONE)) - 64 * ONE,
                            int'($urandom_range(0, 128 * ONE)) - 64 * ONE,
                            $urandom_range(ONE / 2, 4 * ONE)));
        end else if (r < 20) begin
          it = load_of($urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom,
                       $urandom);
          it.dir_x = $urandom; it.dir_y = $urandom; it.dir_z = $urandom;
          send_item(it);
        end else if (r < 85) begin
          send_item(aimed_ray());
        end else begin
          it = ray_of($urandom, $urandom, $urandom, rand_dir(), rand_dir(), rand_dir());
          it.slot = $urandom; it.kind = $urandom; it.size = $urandom;
          send_item(it);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    regs = '{active_bodies: 5'd6, step_limit: 8'd100, distance_limit: 31'd9830400,
             hit_threshold: 16'd655};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_scene_and_defaults();
    test_directed();
    test_backpressure();
    test_random(275);
    wait_idle();
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/sst_pkg.sv
src/sst_front.sv
src/sst_isqrt.sv
src/sst_march.sv
src/sdf_sphere_tracer.sv
src/sst_checker.sv
tb/sv/testbench.sv
